/* hw/rtl/b64d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Default depth of the job queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;

    // Alphabet offsets and special characters
    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;
    localparam logic [7:0] CHAR_PAD          = 8'h3D;   // '='
    localparam logic [7:0] CHAR_PLUS         = 8'h2B;   // '+'
    localparam logic [7:0] CHAR_SLASH        = 8'h2F;   // '/'
    localparam logic [7:0] CHAR_UPPER_A      = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z      = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A      = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z      = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0      = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9      = 8'h39;

    // Input beat
    typedef struct packed {
        logic [7:0] char_in;
        logic       is_final;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
        logic       decode_error;
    } t_out_beat;

    // One queued job: up to three bytes, sent most significant first
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  num_results;   // 1..3
        logic        has_data;      // 0: single empty end-of-message beat
        logic        msg_end;
        logic        err;
    } t_job;

    // Sextet lookup result
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.valid = 1'b1;
        s.value = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            s.value = 6'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            s.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            s.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
        end else if (c == CHAR_PLUS) begin
            s.value = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            s.value = SEXTET_SLASH;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

/* hw/rtl/base64_stream_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: front classifies characters, back emits bytes.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the job queue is not full; the back
// sends one beat per cycle while a job is queued and the output is not stalled.
// A job's beats pass through the job queue and then the output register; a full quad sends three beats in order.
// Input stall rises only while the job queue (P_FIFO_DEPTH jobs) is full.
// Reset (synchronous, active low) clears quad state, queue and output valid.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core #(
    parameter int unsigned P_FIFO_DEPTH = b64d_pkg::FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  b64d_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output b64d_pkg::t_out_beat o_out_data
);
    import b64d_pkg::*;

    logic push;
    logic pop;
    logic fifo_empty;
    logic fifo_full;
    t_job job_in;
    t_job job_head;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_job       (job_in)
    );

    b64d_job_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (job_head),
        .i_empty     (fifo_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* hw/rtl/b64d_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, tracks quad state and pushes jobs.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  b64d_pkg::t_in_beat i_in_data,
    input  logic               i_fifo_full,
    output logic               o_push,
    output b64d_pkg::t_job     o_job
);
    import b64d_pkg::*;

    logic [1:0]  r_qpos,   n_qpos;
    logic [1:0]  r_cnt,    n_cnt;
    logic [17:0] r_acc,    n_acc;
    logic        r_halted, n_halted;
    logic        r_err,    n_err;

    logic        accept;
    logic        emit;
    t_sextet     sx;
    logic [23:0] acc_shift;
    t_job        job;

    assign o_in_stall = i_fifo_full;
    assign accept     = i_in_valid && !i_fifo_full;
    assign sx         = sextet_of(i_in_data.char_in);
    assign acc_shift  = {r_acc, sx.value};

    // Classify the character and build the job
    always_comb begin
        n_qpos   = r_qpos;
        n_cnt    = r_cnt + 2'd1;
        n_acc    = r_acc;
        n_halted = r_halted;
        n_err    = r_err;
        emit     = 1'b0;
        job      = '0;

        if (!r_halted) begin
            if (sx.valid) begin
                if (r_qpos == 2'd3) begin
                    job.word        = acc_shift;
                    job.num_results = 2'd3;
                    job.has_data    = 1'b1;
                    emit            = 1'b1;
                    n_qpos          = '0;
                    n_acc           = '0;
                end else begin
                    n_qpos = r_qpos + 2'd1;
                    n_acc  = acc_shift[17:0];
                end
            end else if (i_in_data.char_in == CHAR_PAD) begin
                if (r_qpos == 2'd2) begin
                    job.word        = {r_acc[11:0], 12'd0};
                    job.num_results = 2'd1;
                    job.has_data    = 1'b1;
                    emit            = 1'b1;
                end else if (r_qpos == 2'd3) begin
                    job.word        = {r_acc, 6'd0};
                    job.num_results = 2'd2;
                    job.has_data    = 1'b1;
                    emit            = 1'b1;
                end
                n_halted = 1'b1;
            end else begin
                n_err    = 1'b1;
                n_halted = 1'b1;
            end
        end

        // End of message: close out and clear state
        if (i_in_data.is_final) begin
            if (!emit) begin
                job.word        = '0;
                job.num_results = 2'd1;
                job.has_data    = 1'b0;
            end
            emit        = 1'b1;
            job.msg_end = 1'b1;
            job.err     = n_err || (n_cnt != 2'd0);
            n_qpos      = '0;
            n_cnt       = '0;
            n_acc       = '0;
            n_halted    = 1'b0;
            n_err       = 1'b0;
        end
    end

    assign o_push = accept && emit;
    assign o_job  = job;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qpos   <= '0;
            r_cnt    <= '0;
            r_acc    <= '0;
            r_halted <= 1'b0;
            r_err    <= 1'b0;
        end else if (accept) begin
            r_qpos   <= n_qpos;
            r_cnt    <= n_cnt;
            r_acc    <= n_acc;
            r_halted <= n_halted;
            r_err    <= n_err;
        end
    end

endmodule

/* hw/rtl/b64d_job_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_job_fifo
// Short register queue of decode jobs between front and back.
// ----------------------------------------------------------------------------
module b64d_job_fifo #(
    parameter int unsigned DEPTH = b64d_pkg::FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    input  logic           i_pop,
    output b64d_pkg::t_job o_head,
    output logic           o_empty,
    output logic           o_full
);
    import b64d_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

/* hw/rtl/b64d_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Splits each queued job into output beats, one per cycle while the output is not stalled, into a register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64d_pkg::t_job      i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output b64d_pkg::t_out_beat o_out_data
);
    import b64d_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_beat  r_out;
    t_out_beat  n_out;
    logic       load;
    logic       last_of_job;

    assign load        = !i_empty && (!r_out_valid || !i_out_stall);
    assign last_of_job = (r_idx == i_head.num_results - 2'd1);
    assign o_pop       = load && last_of_job;

    // Pick the byte for the current beat
    always_comb begin
        n_out = '0;
        unique case (r_idx)
            2'd0:    n_out.data_byte = i_head.word[23:16];
            2'd1:    n_out.data_byte = i_head.word[15:8];
            default: n_out.data_byte = i_head.word[7:0];
        endcase
        n_out.byte_valid   = i_head.has_data;
        n_out.message_end  = i_head.msg_end && last_of_job;
        n_out.decode_error = i_head.err && i_head.msg_end && last_of_job;
    end

    // Byte index within the job and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_idx       <= last_of_job ? 2'd0 : r_idx + 2'd1;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming base64 decoder core. A bit-accurate
// predictor in this file tracks quad position, length and halt state and
// queues the output beats each accepted character should produce. A checker
// compares every output beat field by field, in order. The stimulus starts
// with hand-picked messages (alphabet edges, padding in every quad position,
// bad characters, characters after stop, odd lengths) and then runs random
// messages, mostly well formed, the rest junk or broken. The sender idles in
// random bursts and the receiver stalls on a moded pattern of its own.
// ----------------------------------------------------------------------------
module tb_top;
    import b64d_pkg::*;

    localparam int unsigned CHAR_TARGET  = 310;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned REPORT_MAX   = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_BURSTY
    } stall_mode_e;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    // Predictor state
    logic [1:0]  m_pos    = '0;
    logic [1:0]  m_count  = '0;
    logic [23:0] m_acc    = '0;
    logic        m_halted = 1'b0;
    logic        m_error  = 1'b0;

    t_out_beat   decoded_beats[$];
    int unsigned n_fail      = 0;
    int unsigned n_sent      = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;

    stall_mode_e stall_mode  = STALL_NONE;
    int unsigned stall_left  = 0;

    always #2 clk = ~clk;

    base64_stream_decoder_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_beat)
    );

    // Alphabet lookup: bit 6 set when c is a base64 digit
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return {1'b1, 6'(c - CHAR_UPPER_A)};
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            return {1'b1, 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE};
        end
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            return {1'b1, 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE};
        end
        if (c == CHAR_PLUS) return {1'b1, SEXTET_PLUS};
        if (c == CHAR_SLASH) return {1'b1, SEXTET_SLASH};
        return '0;
    endfunction

    // Inverse map, for building well-formed text
    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < SEXTET_LOWER_BASE) return CHAR_UPPER_A + 8'(v);
        if (v < SEXTET_DIGIT_BASE) return CHAR_LOWER_A + 8'(v - SEXTET_LOWER_BASE);
        if (v < SEXTET_PLUS) return CHAR_DIGIT_0 + 8'(v - SEXTET_DIGIT_BASE);
        if (v == SEXTET_PLUS) return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    function automatic t_out_beat byte_beat(input logic [7:0] b);
        t_out_beat r;
        r = '0;
        r.data_byte  = b;
        r.byte_valid = 1'b1;
        return r;
    endfunction

    // Advance the predictor by one character and queue the beats it yields
    task automatic decode_char(input logic [7:0] c, input logic fin);
        t_out_beat   produced[$];
        logic [6:0]  sx;
        logic [23:0] word;
        m_count = m_count + 2'd1;
        if (!m_halted) begin
            sx = sextet_lookup(c);
            if (sx[6]) begin
                m_acc = {m_acc[17:0], sx[5:0]};
                if (m_pos == 2'd3) begin
                    produced.push_back(byte_beat(m_acc[23:16]));
                    produced.push_back(byte_beat(m_acc[15:8]));
                    produced.push_back(byte_beat(m_acc[7:0]));
                    m_pos = '0;
                    m_acc = '0;
                end else begin
                    m_pos = m_pos + 2'd1;
                end
            end else if (c == CHAR_PAD) begin
                // pad in slot 2 or 3 flushes the partial quad; earlier gives nothing
                if (m_pos >= 2'd2) begin
                    word = m_acc << (6 * (4 - m_pos));
                    produced.push_back(byte_beat(word[23:16]));
                    if (m_pos == 2'd3) produced.push_back(byte_beat(word[15:8]));
                end
                m_halted = 1'b1;
            end else begin
                m_error  = 1'b1;
                m_halted = 1'b1;
            end
        end
        if (fin) begin
            if (produced.size() == 0) produced.push_back('0);
            produced[$].message_end  = 1'b1;
            produced[$].decode_error = m_error || (m_count != 2'd0);
            m_pos    = '0;
            m_count  = '0;
            m_acc    = '0;
            m_halted = 1'b0;
            m_error  = 1'b0;
        end
        foreach (produced[k]) decoded_beats.push_back(produced[k]);
    endtask

    // Send one character beat, with a random gap between bursts
    task automatic send_char(input logic [7:0] c, input logic fin);
        int unsigned gap;
        t_in_beat    b;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        b.char_in  = c;
        b.is_final = fin;
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_sent++;
        decode_char(c, fin);
    endtask

    task automatic send_text(input string s, input logic fin_last);
        for (int k = 0; k < s.len(); k++) begin
            send_char(s[k], fin_last && (k == s.len() - 1));
        end
    endtask

    // Every alphabet boundary; full quad closing on the final beat
    task automatic test_alphabet_edges();
        send_text("+/09azAZ", 1'b1);
    endtask

    // Pad in each quad slot, plus characters after the stop
    task automatic test_padding();
        send_text("QQ==", 1'b1);
        send_text("QUE=", 1'b1);
        send_text("Q=", 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("=", 1'b1);
    endtask

    // Bad character as the only, final beat: empty end beat with error
    task automatic test_bad_char();
        send_char(8'h00, 1'b1);
    endtask

    // Random messages: mostly well formed, the rest padded oddly or junk
    task automatic test_random_messages();
        logic [7:0]  msg[$];
        int unsigned kind;
        int unsigned nq;
        int unsigned pos;
        while (n_sent < CHAR_TARGET) begin
            msg.delete();
            kind = $urandom_range(0, 9);
            nq   = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
            repeat (nq * 4) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
            case (kind)
                0, 1, 2, 3: begin
                    if (msg.size() == 0) begin
                        repeat (4) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
                    end
                end
                4: begin
                    repeat (3) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
                    msg.push_back(CHAR_PAD);
                end
                5: begin
                    repeat (2) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
                    msg.push_back(CHAR_PAD);
                    msg.push_back(CHAR_PAD);
                end
                6: begin
                    // unfinished quad: length error
                    repeat ($urandom_range(1, 3)) begin
                        msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
                    end
                end
                7: begin
                    // pad at a random slot, then trailing junk
                    repeat ($urandom_range(0, 3)) begin
                        msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
                    end
                    msg.push_back(CHAR_PAD);
                    repeat ($urandom_range(0, 5)) msg.push_back(8'($urandom_range(0, 255)));
                end
                8: begin
                    // one random byte or pad dropped in somewhere
                    repeat (4) msg.push_back(alphabet_char(6'($urandom_range(0, 63))));
                    pos      = $urandom_range(0, msg.size() - 1);
                    msg[pos] = ($urandom_range(0, 3) == 0) ? CHAR_PAD : 8'($urandom_range(0, 255));
                end
                default: begin
                    msg.delete();
                    repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            foreach (msg[k]) send_char(msg[k], k == msg.size() - 1);
        end
    endtask

    // Receiver stall pattern: modes of random length
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
            stall_left <= $urandom_range(10, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
            STALL_BURSTY: out_stall <= ((stall_left % 7) < 5);
            default:      out_stall <= 1'b0;
        endcase
    end

    // Output beat check against the predicted queue
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n && out_valid && !out_stall) begin
            if (decoded_beats.size() == 0) begin
                n_fail++;
                if (n_fail <= REPORT_MAX) begin
                    $display("%0t: unexpected beat byte=%02h v=%0d end=%0d err=%0d", $realtime,
                             out_beat.data_byte, out_beat.byte_valid,
                             out_beat.message_end, out_beat.decode_error);
                end
            end else begin
                want = decoded_beats.pop_front();
                if (out_beat.data_byte !== want.data_byte
                        || out_beat.byte_valid !== want.byte_valid
                        || out_beat.message_end !== want.message_end
                        || out_beat.decode_error !== want.decode_error) begin
                    n_fail++;
                    if (n_fail <= REPORT_MAX) begin
                        $display("%0t: mismatch exp byte=%02h v=%0d end=%0d err=%0d",
                                 $realtime, want.data_byte, want.byte_valid,
                                 want.message_end, want.decode_error);
                        $display("%0t:          got byte=%02h v=%0d end=%0d err=%0d",
                                 $realtime, out_beat.data_byte, out_beat.byte_valid,
                                 out_beat.message_end, out_beat.decode_error);
                    end
                end
            end
        end
    end

    // Watchdog: too long without a beat on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_alphabet_edges();
        test_padding();
        test_bad_char();
        test_random_messages();
        in_valid <= 1'b0;
        while (decoded_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        n_fail = n_fail + decoded_beats.size();
        if (n_fail == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
